[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/cbq_pkg.sv]
// ---------------------------------------------------------------------------
// cbq_pkg
// Types, register indexes and reset constants for the complex biquad cascade.
// ---------------------------------------------------------------------------
package cbq_pkg;

    localparam int DEF_SAMPLE_WIDTH = 32;
    localparam int DEF_COEF_WIDTH   = 18;
    localparam int FRAC_BITS        = 16;
    localparam int NUM_REGS         = 8;
    localparam int REG_IDX_W        = 3;
    localparam int LINE_W           = 8;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_S1_FB1   = 3'd0;
    localparam reg_idx_t REG_S1_FB2   = 3'd1;
    localparam reg_idx_t REG_S2_FB1   = 3'd2;
    localparam reg_idx_t REG_S2_FB2   = 3'd3;
    localparam reg_idx_t REG_S1_MID   = 3'd4;
    localparam reg_idx_t REG_S2_MID   = 3'd5;
    localparam reg_idx_t REG_IN_GAIN  = 3'd6;
    localparam reg_idx_t REG_MID_GAIN = 3'd7;

    localparam int COEF_RESET [NUM_REGS] = '{
        114454, -53774, 97914, -37221, -102217, -21258, 11031, 2890
    };

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef enum logic [3:0] {
        STEP_S1_FB1,
        STEP_S1_FB2,
        STEP_S1_GAIN,
        STEP_S1_SUM,
        STEP_W1,
        STEP_T_SUM,
        STEP_T,
        STEP_S2_FB2,
        STEP_S2_GAIN,
        STEP_S2_SUM,
        STEP_W2,
        STEP_Y_SUM,
        STEP_Y
    } step_t;

    typedef enum logic [2:0] {
        OPA_D0,
        OPA_D1,
        OPA_D2,
        OPA_D3,
        OPA_X,
        OPA_T
    } opa_sel_t;

    typedef enum logic [2:0] {
        EXT_ZERO,
        EXT_D1,
        EXT_D3,
        EXT_W1,
        EXT_W2
    } ext_sel_t;

    typedef enum logic [1:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_HOLD
    } acc_op_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_W1,
        CAP_T,
        CAP_W2,
        CAP_Y
    } cap_t;

    typedef struct packed {
        opa_sel_t opa_sel;
        reg_idx_t coef_sel;
        ext_sel_t ext_sel;
        acc_op_t  acc_op;
        cap_t     cap;
        logic     chan;
        logic     busy;
        logic     advance;
        logic     finish;
    } cbq_ctrl_t;

endpackage

[src/cbq_mac.sv]
// ---------------------------------------------------------------------------
// cbq_mac
// Shared multiply-accumulate unit with Q.16 rounding and sample saturation.
// ---------------------------------------------------------------------------
module cbq_mac #(
    parameter int SAMPLE_WIDTH = cbq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = cbq_pkg::DEF_COEF_WIDTH,
    parameter int T_WIDTH      = SAMPLE_WIDTH + COEF_WIDTH - 14,
    parameter int ACC_WIDTH    = SAMPLE_WIDTH + 2 * COEF_WIDTH - 12
) (
    input  logic                           aclk,
    input  logic signed [T_WIDTH-1:0]      op_a,
    input  logic signed [COEF_WIDTH-1:0]   op_b,
    input  logic signed [ACC_WIDTH-1:0]    ext_term,
    input  cbq_pkg::acc_op_t               acc_op,
    output logic signed [T_WIDTH-1:0]      rn_out,
    output logic signed [SAMPLE_WIDTH-1:0] sat_out
);

    localparam int PROD_W = T_WIDTH + COEF_WIDTH;
    localparam int RN_W   = ACC_WIDTH - cbq_pkg::FRAC_BITS;
    localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
        ACC_WIDTH'(1) << (cbq_pkg::FRAC_BITS - 1);

    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic signed [ACC_WIDTH-1:0] prod_ext;
    logic signed [RN_W-1:0]      rn;
    logic                        in_range;

    assign prod_ext = {{(ACC_WIDTH-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb begin
        case (acc_op)
            cbq_pkg::ACC_LOAD: acc_next = ROUND_BIAS + ext_term;
            cbq_pkg::ACC_ADD:  acc_next = acc_reg + prod_ext + ext_term;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    assign rn       = acc_reg[ACC_WIDTH-1:cbq_pkg::FRAC_BITS];
    assign rn_out   = rn[T_WIDTH-1:0];
    assign in_range = (&rn[RN_W-1:SAMPLE_WIDTH-1]) || !(|rn[RN_W-1:SAMPLE_WIDTH-1]);

    always_comb begin
        if (in_range) begin
            sat_out = rn[SAMPLE_WIDTH-1:0];
        end else if (rn[RN_W-1]) begin
            sat_out = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            sat_out = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

endmodule

[src/cbq_seq.sv]
// ---------------------------------------------------------------------------
// cbq_seq
// Step sequencer driving the shared MAC through both biquads, I then Q.
// ---------------------------------------------------------------------------
module cbq_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic               out_full,
    output cbq_pkg::cbq_ctrl_t ctrl
);

    cbq_pkg::seq_state_t state_reg, state_next;
    cbq_pkg::step_t      step_reg, step_next;
    logic                chan_reg, chan_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbq_pkg::SEQ_IDLE;
            step_reg  <= cbq_pkg::STEP_S1_FB1;
            chan_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            chan_reg  <= chan_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        chan_next     = chan_reg;
        ctrl          = '0;
        ctrl.opa_sel  = cbq_pkg::OPA_D0;
        ctrl.coef_sel = cbq_pkg::REG_S1_FB1;
        ctrl.ext_sel  = cbq_pkg::EXT_ZERO;
        ctrl.acc_op   = cbq_pkg::ACC_HOLD;
        ctrl.cap      = cbq_pkg::CAP_NONE;
        ctrl.chan     = chan_reg;
        ctrl.busy     = (state_reg == cbq_pkg::SEQ_RUN);

        case (step_reg)
            cbq_pkg::STEP_S1_FB1: begin
                ctrl.acc_op = cbq_pkg::ACC_LOAD;
            end
            cbq_pkg::STEP_S1_FB2: begin
                ctrl.opa_sel  = cbq_pkg::OPA_D1;
                ctrl.coef_sel = cbq_pkg::REG_S1_FB2;
                ctrl.acc_op   = cbq_pkg::ACC_ADD;
            end
            cbq_pkg::STEP_S1_GAIN: begin
                ctrl.opa_sel  = cbq_pkg::OPA_X;
                ctrl.coef_sel = cbq_pkg::REG_IN_GAIN;
                ctrl.acc_op   = cbq_pkg::ACC_ADD;
            end
            cbq_pkg::STEP_S1_SUM: begin
                ctrl.acc_op = cbq_pkg::ACC_ADD;
            end
            cbq_pkg::STEP_W1: begin
                ctrl.coef_sel = cbq_pkg::REG_S1_MID;
                ctrl.ext_sel  = cbq_pkg::EXT_D1;
                ctrl.acc_op   = cbq_pkg::ACC_LOAD;
                ctrl.cap      = cbq_pkg::CAP_W1;
            end
            cbq_pkg::STEP_T_SUM: begin
                ctrl.ext_sel = cbq_pkg::EXT_W1;
                ctrl.acc_op  = cbq_pkg::ACC_ADD;
            end
            cbq_pkg::STEP_T: begin
                ctrl.opa_sel  = cbq_pkg::OPA_D2;
                ctrl.coef_sel = cbq_pkg::REG_S2_FB1;
                ctrl.acc_op   = cbq_pkg::ACC_LOAD;
                ctrl.cap      = cbq_pkg::CAP_T;
            end
            cbq_pkg::STEP_S2_FB2: begin
                ctrl.opa_sel  = cbq_pkg::OPA_D3;
                ctrl.coef_sel = cbq_pkg::REG_S2_FB2;
                ctrl.acc_op   = cbq_pkg::ACC_ADD;
            end
            cbq_pkg::STEP_S2_GAIN: begin
                ctrl.opa_sel  = cbq_pkg::OPA_T;
                ctrl.coef_sel = cbq_pkg::REG_MID_GAIN;
                ctrl.acc_op   = cbq_pkg::ACC_ADD;
            end
            cbq_pkg::STEP_S2_SUM: begin
                ctrl.acc_op = cbq_pkg::ACC_ADD;
            end
            cbq_pkg::STEP_W2: begin
                ctrl.opa_sel  = cbq_pkg::OPA_D2;
                ctrl.coef_sel = cbq_pkg::REG_S2_MID;
                ctrl.ext_sel  = cbq_pkg::EXT_D3;
                ctrl.acc_op   = cbq_pkg::ACC_LOAD;
                ctrl.cap      = cbq_pkg::CAP_W2;
            end
            cbq_pkg::STEP_Y_SUM: begin
                ctrl.ext_sel = cbq_pkg::EXT_W2;
                ctrl.acc_op  = cbq_pkg::ACC_ADD;
            end
            cbq_pkg::STEP_Y: begin
                ctrl.cap = cbq_pkg::CAP_Y;
            end
            default: begin
                ctrl.acc_op = cbq_pkg::ACC_HOLD;
            end
        endcase

        case (state_reg)
            cbq_pkg::SEQ_IDLE: begin
                ctrl.cap = cbq_pkg::CAP_NONE;
                if (start) begin
                    state_next = cbq_pkg::SEQ_RUN;
                    step_next  = cbq_pkg::STEP_S1_FB1;
                    chan_next  = 1'b0;
                end
            end
            cbq_pkg::SEQ_RUN: begin
                if (step_reg == cbq_pkg::STEP_Y) begin
                    if (!chan_reg) begin
                        ctrl.advance = 1'b1;
                        step_next    = cbq_pkg::STEP_S1_FB1;
                        chan_next    = 1'b1;
                    end else if (!out_full) begin
                        ctrl.advance = 1'b1;
                        ctrl.finish  = 1'b1;
                        state_next   = cbq_pkg::SEQ_IDLE;
                    end
                end else begin
                    step_next = cbq_pkg::step_t'(step_reg + 4'd1);
                end
            end
            default: begin
                state_next = cbq_pkg::SEQ_IDLE;
            end
        endcase
    end

endmodule

[src/complex_biquad_cascade_iir.sv]
// ---------------------------------------------------------------------------
// complex_biquad_cascade_iir
// Two cascaded direct-form-II biquads applied to I and Q, with a line-change
// clear of the delay state and saturated Q16.16 results.
// ---------------------------------------------------------------------------
//  channel   ports                                     transfer when
//  input     s_valid s_ready s_sample_* s_line_number  s_valid & s_ready
//  result    m_valid m_ready m_filtered_*              m_valid & m_ready
//  config    cfg_wr_en cfg_addr cfg_wr_data            cfg_wr_en
//
// Each item runs 13 MAC steps for I, then 13 for Q, and the sequencer returns to idle.
// The multiplier and accumulator are shared, so no new item is taken until it is idle.
// Reset is synchronous and active low; it clears delays, last line and
// coefficients to their defaults. A result not yet taken holds the Q
// channel's final step until m_ready frees the output register.
module complex_biquad_cascade_iir #(
    parameter int SAMPLE_WIDTH = cbq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = cbq_pkg::DEF_COEF_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample_real,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample_imag,
    input  logic [cbq_pkg::LINE_W-1:0]          s_line_number,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      m_filtered_real,
    output logic signed [SAMPLE_WIDTH-1:0]      m_filtered_imag,
    input  logic                                cfg_wr_en,
    input  cbq_pkg::reg_idx_t                   cfg_addr,
    input  logic signed [COEF_WIDTH-1:0]        cfg_wr_data
);

`include "assert_macros.svh"

    localparam int T_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH - 14;
    localparam int ACC_WIDTH = SAMPLE_WIDTH + 2 * COEF_WIDTH - 12;
    localparam int SIGN_PAD  = ACC_WIDTH - SAMPLE_WIDTH - cbq_pkg::FRAC_BITS;

    cbq_pkg::cbq_ctrl_t ctrl;

    logic signed [COEF_WIDTH-1:0]   coef_reg [cbq_pkg::NUM_REGS];
    logic signed [SAMPLE_WIDTH-1:0] re_d_reg [4];
    logic signed [SAMPLE_WIDTH-1:0] im_d_reg [4];
    logic [cbq_pkg::LINE_W-1:0]     last_line_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_re_reg, x_im_reg;
    logic signed [SAMPLE_WIDTH-1:0] w1_reg, w2_reg, y_re_reg;
    logic signed [T_WIDTH-1:0]      t_reg;
    logic                           m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] m_re_reg, m_im_reg;

    logic signed [SAMPLE_WIDTH-1:0] d_cur [4];
    logic signed [SAMPLE_WIDTH-1:0] x_cur;
    logic signed [SAMPLE_WIDTH-1:0] opa_sample;
    logic signed [T_WIDTH-1:0]      op_a;
    logic signed [ACC_WIDTH-1:0]    ext_term;
    logic signed [SAMPLE_WIDTH-1:0] ext_src;
    logic signed [T_WIDTH-1:0]      rn_out;
    logic signed [SAMPLE_WIDTH-1:0] sat_out;
    logic                           in_xfer;
    logic                           out_full;

    assign in_xfer  = s_valid && s_ready;
    assign out_full = m_valid_reg && !m_ready;
    assign s_ready  = !ctrl.busy;
    assign m_valid  = m_valid_reg;
    assign m_filtered_real = m_re_reg;
    assign m_filtered_imag = m_im_reg;

    cbq_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_xfer),
        .out_full (out_full),
        .ctrl     (ctrl)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            d_cur[i] = ctrl.chan ? im_d_reg[i] : re_d_reg[i];
        end
        x_cur = ctrl.chan ? x_im_reg : x_re_reg;
    end

    always_comb begin
        opa_sample = d_cur[0];
        case (ctrl.opa_sel)
            cbq_pkg::OPA_D0: opa_sample = d_cur[0];
            cbq_pkg::OPA_D1: opa_sample = d_cur[1];
            cbq_pkg::OPA_D2: opa_sample = d_cur[2];
            cbq_pkg::OPA_D3: opa_sample = d_cur[3];
            cbq_pkg::OPA_X:  opa_sample = x_cur;
            default:         opa_sample = d_cur[0];
        endcase
        if (ctrl.opa_sel == cbq_pkg::OPA_T) begin
            op_a = t_reg;
        end else begin
            op_a = {{(T_WIDTH-SAMPLE_WIDTH){opa_sample[SAMPLE_WIDTH-1]}}, opa_sample};
        end
    end

    always_comb begin
        case (ctrl.ext_sel)
            cbq_pkg::EXT_D1: ext_src = d_cur[1];
            cbq_pkg::EXT_D3: ext_src = d_cur[3];
            cbq_pkg::EXT_W1: ext_src = w1_reg;
            cbq_pkg::EXT_W2: ext_src = w2_reg;
            default:         ext_src = '0;
        endcase
        ext_term = {{SIGN_PAD{ext_src[SAMPLE_WIDTH-1]}}, ext_src,
                    {cbq_pkg::FRAC_BITS{1'b0}}};
    end

    cbq_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .T_WIDTH      (T_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_mac (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (coef_reg[ctrl.coef_sel]),
        .ext_term (ext_term),
        .acc_op   (ctrl.acc_op),
        .rn_out   (rn_out),
        .sat_out  (sat_out)
    );

    // coefficients
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cbq_pkg::NUM_REGS; i++) begin
                coef_reg[i] <= COEF_WIDTH'(cbq_pkg::COEF_RESET[i]);
            end
        end else if (cfg_wr_en) begin
            coef_reg[cfg_addr] <= cfg_wr_data;
        end
    end

    // delay state and line tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                re_d_reg[i] <= '0;
                im_d_reg[i] <= '0;
            end
            last_line_reg <= '0;
        end else if (in_xfer) begin
            if (s_line_number != last_line_reg) begin
                for (int i = 0; i < 4; i++) begin
                    re_d_reg[i] <= '0;
                    im_d_reg[i] <= '0;
                end
            end
            last_line_reg <= s_line_number;
        end else if (ctrl.cap == cbq_pkg::CAP_Y && ctrl.advance) begin
            if (ctrl.chan) begin
                im_d_reg[0] <= w1_reg;
                im_d_reg[1] <= im_d_reg[0];
                im_d_reg[2] <= w2_reg;
                im_d_reg[3] <= im_d_reg[2];
            end else begin
                re_d_reg[0] <= w1_reg;
                re_d_reg[1] <= re_d_reg[0];
                re_d_reg[2] <= w2_reg;
                re_d_reg[3] <= re_d_reg[2];
            end
        end
    end

    // working values
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            x_re_reg <= s_sample_real;
            x_im_reg <= s_sample_imag;
        end
        case (ctrl.cap)
            cbq_pkg::CAP_W1: w1_reg <= sat_out;
            cbq_pkg::CAP_T:  t_reg  <= rn_out;
            cbq_pkg::CAP_W2: w2_reg <= sat_out;
            cbq_pkg::CAP_Y: begin
                if (!ctrl.chan) begin
                    y_re_reg <= sat_out;
                end
            end
            default: begin
            end
        endcase
        if (ctrl.finish) begin
            m_re_reg <= y_re_reg;
            m_im_reg <= sat_out;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_xfer, !s_ready)
    `ASSERT_NEXT(a_no_result_after_accept, aclk, aresetn, in_xfer, !$rose(m_valid))
    `ASSERT_NEXT(a_line_change_clears, aclk, aresetn,
        in_xfer && (s_line_number != last_line_reg),
        re_d_reg[0] == '0 && re_d_reg[1] == '0 && re_d_reg[2] == '0 &&
        re_d_reg[3] == '0 && im_d_reg[0] == '0 && im_d_reg[3] == '0)
    `ASSERT_ALWAYS(a_finish_needs_room, aclk, aresetn, !(ctrl.finish && out_full))

endmodule
